// ===== hdl/lru_pft_pkg.sv =====
// lru_pft_pkg: shared constants and types for the lru page-frame table unit
// field widths, parameter defaults and the reset value of the frame count
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lru_pft_pkg;

    // parameter defaults
    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    // fixed port field widths
    localparam int PAGE_W  = 16;
    localparam int FIDX_W  = 4;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 5;

    // frame count after reset
    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

    // saturation point of the running counts
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // one result transaction
    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] fault_count;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/lru_page_frame_table_unit.sv =====
// lru_page_frame_table_unit: fully associative page-frame table, lru replacement
// one reference per cycle while out_ready does not stall the output; depends on lru_pft_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one page reference per transaction,
//   page_number plus restart; restart empties the table and zeroes both counts
//   before the reference is handled.
//   output channel (out_valid/out_ready) returns one result per reference:
//   hit, frame_index, evicted_valid/evicted_page and the running hit/fault counts.
//   config channel (cfg_valid/cfg_ready) writes frames_in_use; always ready, and
//   must only be written while no reference is in flight.
// path: input register, then one pass of tag compare, lru search and rank update
//   into the result register. throughput: 1 reference per cycle while out_ready
//   does not stall, since the frame tags and recency ranks that the next reference
//   reads are updated in the same pass.
// reset: table empty, counts zero, frames_in_use back to 16, no result pending.
// stall: while out_ready is low the result register holds; one more reference
//   waits in the input register, after which in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_frame_table_unit
    import lru_pft_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // references
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [PAGE_W-1:0]  page_number,
    input  wire logic               restart,
    // results
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit,
    output logic [FIDX_W-1:0]       frame_index,
    output logic                    evicted_valid,
    output logic [PAGE_W-1:0]       evicted_page,
    output logic [COUNT_W-1:0]      hit_count,
    output logic [COUNT_W-1:0]      fault_count
);

    // stored page width, rank width, fill count width, frame count compare width
    localparam int PW     = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int NW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_FRAMES);

    // configuration register
    logic [CFG_W-1:0]   frames_cfg_reg;

    // input register
    logic               s1_valid_reg;
    logic [PW-1:0]      s1_page_reg;
    logic               s1_restart_reg;

    // table state
    logic [PW-1:0]      page_reg [MAX_FRAMES];
    logic [IDX_W-1:0]   rank_reg [MAX_FRAMES];
    logic [CNT_W-1:0]   filled_reg;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] faults_reg;

    // result register
    logic               out_valid_reg;
    result_t            res_reg;

    // pass logic
    logic               fire;
    logic [NW-1:0]      n_act;
    logic [CNT_W-1:0]   filled_eff;
    logic [COUNT_W-1:0] hits_eff;
    logic [COUNT_W-1:0] faults_eff;
    logic [NW-1:0]      limit;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] act;
    logic [MAX_FRAMES-1:0] is_lru;
    logic               hit_n;
    logic               room;
    logic [IDX_W-1:0]   hit_slot;
    logic [IDX_W-1:0]   lru_slot;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   r_sel;
    logic [IDX_W-1:0]   rank_next [MAX_FRAMES];
    logic [CNT_W-1:0]   filled_next;
    logic [COUNT_W-1:0] hits_next;
    logic [COUNT_W-1:0] faults_next;
    result_t            res_next;

    // handshakes
    assign cfg_ready = 1'b1;
    assign fire      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || fire;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= FRAMES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_cfg_reg <= cfg_data;
        end
    end

    // active frame count, clamped to 1..MAX_FRAMES
    always_comb
    begin
        n_act = NW'(frames_cfg_reg);
        if (frames_cfg_reg == '0)
        begin
            n_act = NW'(1);
        end
        else if (NW'(frames_cfg_reg) > MAX_N)
        begin
            n_act = MAX_N;
        end
    end

    // restart clears fill count and counts ahead of the lookup
    assign filled_eff = s1_restart_reg ? '0 : filled_reg;
    assign hits_eff   = s1_restart_reg ? '0 : hits_reg;
    assign faults_eff = s1_restart_reg ? '0 : faults_reg;
    assign limit      = (NW'(filled_eff) < n_act) ? NW'(filled_eff) : n_act;
    assign room       = NW'(filled_eff) < n_act;

    // parallel tag compare, lowest matching frame wins
    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            match[i] = (NW'(i) < limit) && (page_reg[i] == s1_page_reg);
        end
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_slot = IDX_W'(i);
            end
        end
    end
    assign hit_n = |match;

    // lru victim: highest rank among active frames, lowest index on a tie
    always_comb
    begin
        lru_slot = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            act[i] = NW'(i) < n_act;
        end
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            is_lru[i] = act[i];
            for (int j = 0; j < MAX_FRAMES; j++)
            begin
                if (act[j] && ((rank_reg[j] > rank_reg[i]) ||
                               ((rank_reg[j] == rank_reg[i]) && (j < i))))
                begin
                    is_lru[i] = 1'b0;
                end
            end
        end
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (is_lru[i])
            begin
                lru_slot = IDX_W'(i);
            end
        end
    end

    // chosen frame and the rank it leaves behind
    always_comb
    begin
        if (hit_n)
        begin
            slot  = hit_slot;
            r_sel = rank_reg[hit_slot];
        end
        else if (room)
        begin
            slot  = IDX_W'(filled_eff);
            r_sel = IDX_W'(filled_eff);
        end
        else
        begin
            slot  = lru_slot;
            r_sel = rank_reg[lru_slot];
        end
    end

    // recency update: chosen frame to zero, more recent filled frames age
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (IDX_W'(i) == slot)
            begin
                rank_next[i] = '0;
            end
            else if ((CNT_W'(i) < filled_eff) && (rank_reg[i] < r_sel))
            begin
                rank_next[i] = rank_reg[i] + IDX_W'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    // fill count and saturating counts
    assign filled_next = (!hit_n && room) ? filled_eff + CNT_W'(1) : filled_eff;
    assign hits_next   = (hit_n && (hits_eff != COUNT_MAX)) ?
                         hits_eff + COUNT_W'(1) : hits_eff;
    assign faults_next = (!hit_n && (faults_eff != COUNT_MAX)) ?
                         faults_eff + COUNT_W'(1) : faults_eff;

    // result assembly
    always_comb
    begin
        res_next.hit           = hit_n;
        res_next.frame_index   = FIDX_W'(slot);
        res_next.evicted_valid = !hit_n && !room;
        res_next.evicted_page  = (!hit_n && !room) ? PAGE_W'(page_reg[slot]) : '0;
        res_next.hit_count     = hits_next;
        res_next.fault_count   = faults_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            filled_reg    <= '0;
            hits_reg      <= '0;
            faults_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                filled_reg    <= filled_next;
                hits_reg      <= hits_next;
                faults_reg    <= faults_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: input stage, table contents, result
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_page_reg    <= PW'(page_number);
            s1_restart_reg <= restart;
        end
        if (fire)
        begin
            res_reg <= res_next;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (!hit_n)
            begin
                page_reg[slot] <= s1_page_reg;
            end
        end
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign hit           = res_reg.hit;
    assign frame_index   = res_reg.frame_index;
    assign evicted_valid = res_reg.evicted_valid;
    assign evicted_page  = res_reg.evicted_page;
    assign hit_count     = res_reg.hit_count;
    assign fault_count   = res_reg.fault_count;

`ifndef SYNTHESIS
    // fill count never passes the table size
    a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        NW'(filled_reg) <= MAX_N)
        else $error("fill count above table size");

    // an eviction is always a fault
    a_evict_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_valid) |-> !hit)
        else $error("eviction reported on a hit");

    // no eviction means no evicted page
    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !evicted_valid) |-> (evicted_page == '0))
        else $error("evicted page set without eviction");

    // a fault with free frames grows the fill count by one
    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !hit_n && room) |=> (filled_reg == $past(filled_eff) + CNT_W'(1)))
        else $error("fill count not advanced on fill");

    // the chosen frame becomes most recent
    a_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rank_reg[$past(slot)] == '0))
        else $error("touched frame not most recent");
`endif

endmodule

`default_nettype wire
